// ===== src/otsa_pkg.sv =====
package otsa_pkg;

  localparam int unsigned MAX_SLOTS_DEF  = 16;
  localparam int unsigned OWNER_BITS_DEF = 16;

  localparam int unsigned CMD_W       = 3;
  localparam int unsigned OUTC_W      = 2;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned DRAW_W      = 15;
  localparam int unsigned OWNER_IN_W  = 16;
  localparam int unsigned SLOT_IN_W   = 4;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_FORCE      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_OCCUPY     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESERVE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEPART_REL = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DEPART_REQ = 3'd6;

  // Slot states
  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_OCC  = 2'd1;
  localparam logic [1:0] ST_RES  = 2'd2;

  // Outcome codes
  localparam logic [OUTC_W-1:0] OUTC_OK   = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_FAIL = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_PEND = 2'd2;

  localparam logic [DRAW_W-1:0] PEND_LIMIT = 15'd16383;

  typedef struct packed {
    logic [4:0]            pad;
    logic [DRAW_W-1:0]     pick_draw;
    logic [DRAW_W-1:0]     pending_draw;
    logic [OWNER_IN_W-1:0] owner_id;
    logic [SLOT_IN_W-1:0]  slot_index;
    logic                  slot_given;
  } in_data_t;

  typedef struct packed {
    logic [2:0]           pad;
    logic [SLOT_IN_W-1:0] result_slot;
    logic                 slot_valid;
  } out_data_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;
    logic              rd_named;
    logic              scan_start;
    logic              scan_go;
    logic              take;
    logic              take_named;
    logic [1:0]        take_status;
    logic              take_dec;
    logic              release_hit;
    logic              set_res;
    logic [OUTC_W-1:0] res_outcome;
    logic              res_valid;
    logic              res_named;
    logic              out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             in_range;
    logic             free_zero;
    logic             pend;
    logic             rd_free;
    logic             hit;
    logic             nth_found;
    logic             scan_done;
    logic             out_free;
  } dp_stat_t;

endpackage

// ===== src/otsa_dp.sv =====
module otsa_dp #(
  parameter int unsigned MAX_SLOTS  = otsa_pkg::MAX_SLOTS_DEF,
  parameter int unsigned OWNER_BITS = otsa_pkg::OWNER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [otsa_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [otsa_pkg::CMD_W-1:0]         in_tuser,
  input  logic                               cfg_fire,
  input  logic [otsa_pkg::CFG_W-1:0]         cfg_tdata,
  input  otsa_pkg::ctrl_cmd_t                cmd,
  output otsa_pkg::dp_stat_t                 stat,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [otsa_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [otsa_pkg::OUTC_W-1:0]        out_tuser
);

  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned PW = otsa_pkg::DRAW_W + CW;

  otsa_pkg::in_data_t  in_d;
  otsa_pkg::out_data_t out_d;

  logic [OWNER_BITS+otsa_pkg::OWNER_IN_W-1:0] owner_ext;
  logic [OWNER_BITS-1:0]                      owner_in;

  // Item registers
  logic [otsa_pkg::CMD_W-1:0]     cmd_r;
  logic                           given_r;
  logic [otsa_pkg::SLOT_IN_W-1:0] slot_r;
  logic [OWNER_BITS-1:0]          owner_r;
  logic [otsa_pkg::DRAW_W-1:0]    pdraw_r;
  logic [otsa_pkg::DRAW_W-1:0]    kdraw_r;

  // Table
  logic [1:0]            stat_mem [MAX_SLOTS];
  logic [OWNER_BITS-1:0] own_mem  [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]  vld_r;
  logic [1:0]            rd_stat_r;
  logic [OWNER_BITS-1:0] rd_own_r;
  logic                  rd_vld_r;

  logic [CW-1:0] slots_r;
  logic [CW-1:0] free_r;
  logic [CW-1:0] cfg_n;

  // Scan
  logic [CW-1:0] idx_r;
  logic [IW-1:0] dat_idx_r;
  logic          live_r;
  logic [CW-1:0] n_r;
  logic [PW-1:0] prod;

  logic [IW-1:0]         rd_addr;
  logic [IW-1:0]         wr_addr;
  logic                  rd_ok;
  logic [1:0]            st_eff;
  logic [OWNER_BITS-1:0] own_eff;
  logic                  own_eq;
  logic                  hit_state;

  // Result and output
  logic [otsa_pkg::OUTC_W-1:0]    res_outcome_r;
  logic                           res_valid_r;
  logic [otsa_pkg::SLOT_IN_W-1:0] res_slot_r;
  logic                           out_valid_r;
  logic [otsa_pkg::OUTC_W-1:0]    out_outcome_r;
  logic                           out_svalid_r;
  logic [otsa_pkg::SLOT_IN_W-1:0] out_slot_r;

  assign in_d      = otsa_pkg::in_data_t'(in_tdata);
  assign owner_ext = {{OWNER_BITS{1'b0}}, in_d.owner_id};
  assign owner_in  = owner_ext[OWNER_BITS-1:0];

  assign cfg_n = (32'(cfg_tdata) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(cfg_tdata);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_tuser;
      given_r <= in_d.slot_given;
      slot_r  <= in_d.slot_index;
      owner_r <= owner_in;
      pdraw_r <= in_d.pending_draw;
      kdraw_r <= in_d.pick_draw;
    end
  end

  assign rd_addr = cmd.rd_named ? IW'(slot_r) : idx_r[IW-1:0];
  assign wr_addr = cmd.take_named ? IW'(slot_r) : dat_idx_r;
  assign rd_ok   = 32'(rd_addr) < MAX_SLOTS;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      stat_mem[wr_addr] <= cmd.take_status;
      own_mem[wr_addr]  <= owner_r;
    end
    rd_stat_r <= stat_mem[rd_addr];
    rd_own_r  <= own_mem[rd_addr];
  end

  // An entry without its valid bit reads as free with a zero owner
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_ok && vld_r[rd_addr];
      if (cfg_fire) begin
        vld_r <= '0;
      end else if (cmd.take) begin
        vld_r[wr_addr] <= 1'b1;
      end else if (cmd.release_hit) begin
        vld_r[dat_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= '0;
      free_r  <= '0;
    end else if (cfg_fire) begin
      slots_r <= cfg_n;
      free_r  <= cfg_n;
    end else if (cmd.take && cmd.take_dec) begin
      free_r <= free_r - CW'(1);
    end else if (cmd.release_hit) begin
      free_r <= free_r + CW'(1);
    end
  end

  assign prod = PW'(kdraw_r) * PW'(free_r);

  assign st_eff    = rd_vld_r ? rd_stat_r : otsa_pkg::ST_FREE;
  assign own_eff   = rd_vld_r ? rd_own_r : '0;
  assign own_eq    = own_eff == owner_r;
  assign hit_state = (cmd_r == otsa_pkg::CMD_QUERY || cmd_r == otsa_pkg::CMD_DEPART_REL) ?
                     (st_eff == otsa_pkg::ST_OCC) : (st_eff != otsa_pkg::ST_FREE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      live_r <= 1'b0;
    end else if (cmd.scan_start) begin
      idx_r  <= '0;
      live_r <= 1'b0;
    end else if (cmd.scan_go) begin
      if (idx_r < slots_r) begin
        idx_r  <= idx_r + CW'(1);
        live_r <= 1'b1;
      end else begin
        live_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_go && idx_r < slots_r) begin
      dat_idx_r <= idx_r[IW-1:0];
    end
    if (cmd.scan_start) begin
      n_r <= prod[PW-1:otsa_pkg::DRAW_W];
    end else if (cmd.scan_go && live_r && st_eff == otsa_pkg::ST_FREE && n_r != '0) begin
      n_r <= n_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_outcome_r <= cmd.res_outcome;
      res_valid_r   <= cmd.res_valid;
      if (!cmd.res_valid) begin
        res_slot_r <= '0;
      end else if (cmd.res_named) begin
        res_slot_r <= slot_r;
      end else begin
        res_slot_r <= otsa_pkg::SLOT_IN_W'(dat_idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_outcome_r <= res_outcome_r;
      out_svalid_r  <= res_valid_r;
      out_slot_r    <= res_slot_r;
    end
  end

  assign stat.cmd       = cmd_r;
  assign stat.in_range  = given_r && (32'(slot_r) < 32'(slots_r));
  assign stat.free_zero = free_r == '0;
  assign stat.pend      = pdraw_r < otsa_pkg::PEND_LIMIT;
  assign stat.rd_free   = st_eff == otsa_pkg::ST_FREE;
  assign stat.hit       = live_r && hit_state && own_eq;
  assign stat.nth_found = live_r && st_eff == otsa_pkg::ST_FREE && n_r == '0;
  assign stat.scan_done = !live_r && !(idx_r < slots_r);
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_d.pad         = '0;
  assign out_d.result_slot = out_slot_r;
  assign out_d.slot_valid  = out_svalid_r;
  assign out_tvalid        = out_valid_r;
  assign out_tdata         = out_d;
  assign out_tuser         = out_outcome_r;

endmodule

// ===== src/otsa_ctrl.sv =====
module otsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                cfg_tready,
  input  otsa_pkg::dp_stat_t  stat,
  output otsa_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_NAMED,
    S_MULT,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign cfg_tready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (stat.cmd)
          otsa_pkg::CMD_FORCE: begin
            if (!stat.in_range) begin
              cmd.set_res     = 1'b1;
              cmd.res_outcome = otsa_pkg::OUTC_FAIL;
              state_nxt       = S_FINISH;
            end else begin
              cmd.rd_named = 1'b1;
              state_nxt    = S_NAMED;
            end
          end
          otsa_pkg::CMD_OCCUPY: begin
            if (stat.free_zero) begin
              cmd.set_res     = 1'b1;
              cmd.res_outcome = otsa_pkg::OUTC_FAIL;
              state_nxt       = S_FINISH;
            end else if (stat.in_range) begin
              cmd.rd_named = 1'b1;
              state_nxt    = S_NAMED;
            end else begin
              state_nxt = S_MULT;
            end
          end
          otsa_pkg::CMD_RELEASE, otsa_pkg::CMD_QUERY, otsa_pkg::CMD_DEPART_REL: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          otsa_pkg::CMD_RESERVE: begin
            if (stat.pend) begin
              cmd.set_res     = 1'b1;
              cmd.res_outcome = otsa_pkg::OUTC_PEND;
              state_nxt       = S_FINISH;
            end else if (stat.free_zero) begin
              cmd.set_res     = 1'b1;
              cmd.res_outcome = otsa_pkg::OUTC_FAIL;
              state_nxt       = S_FINISH;
            end else begin
              state_nxt = S_MULT;
            end
          end
          otsa_pkg::CMD_DEPART_REQ: begin
            cmd.set_res     = 1'b1;
            cmd.res_outcome = stat.pend ? otsa_pkg::OUTC_PEND : otsa_pkg::OUTC_OK;
            state_nxt       = S_FINISH;
          end
          default: begin
            cmd.set_res     = 1'b1;
            cmd.res_outcome = otsa_pkg::OUTC_FAIL;
            state_nxt       = S_FINISH;
          end
        endcase
      end
      S_NAMED: begin
        // Forced occupy always takes the slot; occupy only if it is free
        if (stat.cmd == otsa_pkg::CMD_FORCE || stat.rd_free) begin
          cmd.take        = 1'b1;
          cmd.take_named  = 1'b1;
          cmd.take_status = otsa_pkg::ST_OCC;
          cmd.take_dec    = stat.rd_free;
          cmd.set_res     = 1'b1;
          cmd.res_outcome = otsa_pkg::OUTC_OK;
          cmd.res_valid   = 1'b1;
          cmd.res_named   = 1'b1;
          state_nxt       = S_FINISH;
        end else begin
          state_nxt = S_MULT;
        end
      end
      S_MULT: begin
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_go = 1'b1;
        case (stat.cmd)
          otsa_pkg::CMD_RELEASE, otsa_pkg::CMD_DEPART_REL: begin
            cmd.release_hit = stat.hit;
            if (stat.scan_done) begin
              cmd.set_res     = 1'b1;
              cmd.res_outcome = otsa_pkg::OUTC_OK;
              state_nxt       = S_FINISH;
            end
          end
          otsa_pkg::CMD_QUERY: begin
            if (stat.hit) begin
              cmd.scan_go     = 1'b0;
              cmd.set_res     = 1'b1;
              cmd.res_outcome = otsa_pkg::OUTC_OK;
              cmd.res_valid   = 1'b1;
              state_nxt       = S_FINISH;
            end else if (stat.scan_done) begin
              cmd.set_res     = 1'b1;
              cmd.res_outcome = otsa_pkg::OUTC_FAIL;
              state_nxt       = S_FINISH;
            end
          end
          otsa_pkg::CMD_OCCUPY, otsa_pkg::CMD_RESERVE: begin
            if (stat.nth_found) begin
              cmd.scan_go     = 1'b0;
              cmd.take        = 1'b1;
              cmd.take_status = (stat.cmd == otsa_pkg::CMD_RESERVE) ?
                                otsa_pkg::ST_RES : otsa_pkg::ST_OCC;
              cmd.take_dec    = 1'b1;
              cmd.set_res     = 1'b1;
              cmd.res_outcome = otsa_pkg::OUTC_OK;
              cmd.res_valid   = 1'b1;
              state_nxt       = S_FINISH;
            end else if (stat.scan_done) begin
              cmd.set_res     = 1'b1;
              cmd.res_outcome = (stat.cmd == otsa_pkg::CMD_RESERVE) ?
                                otsa_pkg::OUTC_PEND : otsa_pkg::OUTC_FAIL;
              state_nxt       = S_FINISH;
            end
          end
          default: begin
            cmd.scan_go     = 1'b0;
            cmd.set_res     = 1'b1;
            cmd.res_outcome = otsa_pkg::OUTC_FAIL;
            state_nxt       = S_FINISH;
          end
        endcase
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/owner_tagged_slot_allocator.sv =====
// Slot table of MAX_SLOTS entries, each free, occupied or reserved and tagged
// with an owner, plus a free count. One command per input transaction gives
// exactly one result transaction. A write on the cfg channel sets the number
// of active slots (clamped to MAX_SLOTS), frees the whole table at once and
// loads the free count; write it only while no command is in flight. An item
// waits in the finish state until the output register can take its result,
// and the next command is accepted in the cycle after that load. Commands
// that need no table access finish straight from the decide state, a named
// slot adds one read, and releases, queries and random free picks walk the
// active slots one per cycle through the single read port of the table,
// after a step that primes the read; random picks first scale the pick draw
// by the free count in a step of their own. The result sits in an output
// register, so the next command is accepted while it waits.
module owner_tagged_slot_allocator #(
  parameter int unsigned MAX_SLOTS  = otsa_pkg::MAX_SLOTS_DEF,
  parameter int unsigned OWNER_BITS = otsa_pkg::OWNER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // tdata: slot_given[0], slot_index[4:1], owner_id[20:5],
  //        pending_draw[35:21], pick_draw[50:36], zero pad[55:51]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [otsa_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: command[2:0]
  input  logic [otsa_pkg::CMD_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: slot_valid[0], result_slot[4:1], zero pad[7:5]
  output logic [otsa_pkg::OUT_TDATA_W-1:0] out_tdata,
  // tuser: outcome[1:0]
  output logic [otsa_pkg::OUTC_W-1:0]      out_tuser,
  // slots_in_use write
  input  logic                             cfg_tvalid,
  output logic                             cfg_tready,
  input  logic [otsa_pkg::CFG_W-1:0]       cfg_tdata
);

  otsa_pkg::ctrl_cmd_t cmd;
  otsa_pkg::dp_stat_t  stat;
  logic                cfg_fire;

  // A config transaction completes on valid and ready together
  assign cfg_fire = cfg_tvalid && cfg_tready;

  otsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .cfg_tready (cfg_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  otsa_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .OWNER_BITS (OWNER_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_fire   (cfg_fire),
    .cfg_tdata  (cfg_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // Never decrement the free count past zero
  a_no_free_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && cmd.take_dec |-> !stat.free_zero)
    else $error("free count decremented at zero");

  // Load the output register only when it is empty or being drained
  a_out_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result overwritten before it was taken");

  // A new result appears only after the controller loaded one
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.out_load))
    else $error("result valid without a load");

  // An accepted command blocks the input until its result is queued
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !cfg_tready)
    else $error("second transaction taken while a command is in flight");
`endif

endmodule

// ===== dv/owner_tagged_slot_allocator_checker.sv =====
`timescale 1ns / 1ps
module owner_tagged_slot_allocator_checker
  import otsa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // tdata: slot_given, slot_index, owner_id, pending_draw, pick_draw, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: command
  input  logic [CMD_W-1:0]       in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata: slot_valid, result_slot, zero pad
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  // tuser: outcome
  input  logic [OUTC_W-1:0]      out_tuser,
  input  logic                   cfg_tvalid,
  input  logic                   cfg_tready,
  input  logic [CFG_W-1:0]       cfg_tdata,
  output int                     mismatches,
  output int                     awaited
);

  localparam int unsigned TABLE_DEPTH = MAX_SLOTS_DEF;

  typedef struct packed {
    logic [OUTC_W-1:0]    outcome;
    logic                 slot_valid;
    logic [SLOT_IN_W-1:0] result_slot;
  } slot_reply_t;

  // Shadow copy of the slot table
  logic [1:0]                slot_state [TABLE_DEPTH];
  logic [OWNER_BITS_DEF-1:0] slot_tag   [TABLE_DEPTH];
  int unsigned               free_slots;
  int unsigned               active_slots;

  slot_reply_t replies_due [$];

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void load_slot_count(logic [CFG_W-1:0] n);
    active_slots = (32'(n) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(n);
    free_slots   = active_slots;
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      slot_state[i] = ST_FREE;
      slot_tag[i]   = '0;
    end
  endfunction

  // Position of the n-th free active slot counting up from slot 0, -1 if none
  function automatic int find_free(int unsigned n);
    for (int unsigned i = 0; i < active_slots; i++) begin
      if (slot_state[i] == ST_FREE) begin
        if (n == 0) return int'(i);
        n--;
      end
    end
    return -1;
  endfunction

  function automatic void free_owner(logic [OWNER_BITS_DEF-1:0] tag, bit occupied_only);
    bit hit;
    for (int unsigned i = 0; i < active_slots; i++) begin
      hit = occupied_only ? (slot_state[i] == ST_OCC) : (slot_state[i] != ST_FREE);
      if (hit && slot_tag[i] == tag) begin
        slot_state[i] = ST_FREE;
        slot_tag[i]   = '0;
        free_slots++;
      end
    end
  endfunction

  function automatic void claim_slot(int unsigned i, logic [1:0] st,
                                     logic [OWNER_BITS_DEF-1:0] tag);
    if (slot_state[i] == ST_FREE) free_slots--;
    slot_state[i] = st;
    slot_tag[i]   = tag;
  endfunction

  function automatic slot_reply_t pack_reply(logic [OUTC_W-1:0] oc, logic v,
                                             logic [SLOT_IN_W-1:0] s);
    slot_reply_t r;
    r.outcome     = oc;
    r.slot_valid  = v;
    r.result_slot = v ? s : '0;
    return r;
  endfunction

  function automatic slot_reply_t predict_reply(logic [CMD_W-1:0] cmd, in_data_t d);
    bit          named_ok;
    int unsigned draw;
    int unsigned draw_pos;
    int          pick;
    named_ok = d.slot_given && (32'(d.slot_index) < active_slots);
    draw     = 32'(d.pick_draw);
    draw_pos = (draw * free_slots) >> 15;
    case (cmd)
      CMD_FORCE: begin
        if (!named_ok) return pack_reply(OUTC_FAIL, 1'b0, '0);
        claim_slot(32'(d.slot_index), ST_OCC, d.owner_id);
        return pack_reply(OUTC_OK, 1'b1, d.slot_index);
      end
      CMD_OCCUPY: begin
        if (free_slots == 0) return pack_reply(OUTC_FAIL, 1'b0, '0);
        if (named_ok && slot_state[d.slot_index] == ST_FREE) begin
          claim_slot(32'(d.slot_index), ST_OCC, d.owner_id);
          return pack_reply(OUTC_OK, 1'b1, d.slot_index);
        end
        pick = find_free(draw_pos);
        if (pick < 0) return pack_reply(OUTC_FAIL, 1'b0, '0);
        claim_slot(pick, ST_OCC, d.owner_id);
        return pack_reply(OUTC_OK, 1'b1, pick[SLOT_IN_W-1:0]);
      end
      CMD_RELEASE: begin
        free_owner(d.owner_id, 1'b0);
        return pack_reply(OUTC_OK, 1'b0, '0);
      end
      CMD_QUERY: begin
        for (int unsigned i = 0; i < active_slots; i++) begin
          if (slot_state[i] == ST_OCC && slot_tag[i] == d.owner_id)
            return pack_reply(OUTC_OK, 1'b1, i[SLOT_IN_W-1:0]);
        end
        return pack_reply(OUTC_FAIL, 1'b0, '0);
      end
      CMD_RESERVE: begin
        if (d.pending_draw < PEND_LIMIT) return pack_reply(OUTC_PEND, 1'b0, '0);
        if (free_slots == 0) return pack_reply(OUTC_FAIL, 1'b0, '0);
        pick = find_free(draw_pos);
        if (pick < 0) return pack_reply(OUTC_PEND, 1'b0, '0);
        claim_slot(pick, ST_RES, d.owner_id);
        return pack_reply(OUTC_OK, 1'b1, pick[SLOT_IN_W-1:0]);
      end
      CMD_DEPART_REL: begin
        free_owner(d.owner_id, 1'b1);
        return pack_reply(OUTC_OK, 1'b0, '0);
      end
      CMD_DEPART_REQ: begin
        return pack_reply((d.pending_draw < PEND_LIMIT) ? OUTC_PEND : OUTC_OK, 1'b0, '0);
      end
      default: return pack_reply(OUTC_FAIL, 1'b0, '0);
    endcase
  endfunction

  always @(posedge clk) begin : watch
    slot_reply_t want;
    out_data_t   got;
    if (!rst_n) begin
      load_slot_count('0);
      replies_due.delete();
      mismatches = 0;
      awaited <= 0;
    end else begin
      // results leave only after their command was accepted, so retire first
      if (out_tvalid && out_tready) begin
        got = out_data_t'(out_tdata);
        if (replies_due.size() == 0) begin
          report_mismatch("result with none due, outcome", int'(out_tuser), -1);
        end else begin
          want = replies_due.pop_front();
          if (out_tuser != want.outcome)
            report_mismatch("outcome", int'(out_tuser), int'(want.outcome));
          if (got.slot_valid != want.slot_valid)
            report_mismatch("slot_valid", int'(got.slot_valid), int'(want.slot_valid));
          if (got.result_slot != want.result_slot)
            report_mismatch("result_slot", int'(got.result_slot), int'(want.result_slot));
        end
      end
      if (cfg_tvalid && cfg_tready) load_slot_count(cfg_tdata);
      if (in_tvalid && in_tready)
        replies_due.push_back(predict_reply(in_tuser, in_data_t'(in_tdata)));
      awaited <= replies_due.size();
    end
  end

endmodule

// ===== dv/owner_tagged_slot_allocator_tb.sv =====
`timescale 1ns / 1ps
module owner_tagged_slot_allocator_tb;
  import otsa_pkg::*;

  // Command code with no function in the block
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  localparam int unsigned SETTING_COUNT = 9;
  localparam int unsigned ITEMS_PER_SET = 97;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned POOL_SIZE     = 6;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]       in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUTC_W-1:0]      out_tuser;
  logic                   cfg_tvalid = 1'b0;
  logic                   cfg_tready;
  logic [CFG_W-1:0]       cfg_tdata  = '0;

  int mismatches;
  int awaited;

  // Idle chances in percent per cycle, changed as the run advances
  int unsigned snd_idle   = 26;
  int unsigned rcv_idle   = 52;
  int unsigned items_sent = 0;

  // Long receiver hold-offs: asked by the stimulus, counted by the receiver
  int unsigned holds_asked = 0;
  int unsigned holds_done  = 0;

  // Small set of owner tags so releases and queries actually hit something
  logic [OWNER_IN_W-1:0] owner_pool [POOL_SIZE];

  always #5 clk = ~clk;

  owner_tagged_slot_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  owner_tagged_slot_allocator_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // Offer one command; idle for a random number of cycles first, then hold
  // valid until the transaction goes through. Valid is never dropped between
  // back-to-back commands.
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic given, logic [SLOT_IN_W-1:0] idx,
                          logic [OWNER_IN_W-1:0] owner, logic [DRAW_W-1:0] pdraw,
                          logic [DRAW_W-1:0] kdraw);
    in_data_t word;
    word              = '0;
    word.slot_given   = given;
    word.slot_index   = idx;
    word.owner_id     = owner;
    word.pending_draw = pdraw;
    word.pick_draw    = kdraw;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    // Swap the idle pattern after the first third, stop idling after two thirds
    if (items_sent == 300) begin
      snd_idle = 52;
      rcv_idle = 26;
    end else if (items_sent == 600) begin
      snd_idle = 0;
      rcv_idle = 0;
    end
  endtask

  // Random command: mostly pooled owners, with draws pushed to the pending
  // threshold and to the ends of the pick range now and then.
  task automatic send_random();
    int unsigned           roll;
    logic [CMD_W-1:0]      cmd;
    logic [OWNER_IN_W-1:0] owner;
    logic [DRAW_W-1:0]     pdraw;
    logic [DRAW_W-1:0]     kdraw;
    roll = $urandom_range(0, 99);
    if (roll < 15)      cmd = CMD_FORCE;
    else if (roll < 40) cmd = CMD_OCCUPY;
    else if (roll < 50) cmd = CMD_RELEASE;
    else if (roll < 63) cmd = CMD_QUERY;
    else if (roll < 80) cmd = CMD_RESERVE;
    else if (roll < 88) cmd = CMD_DEPART_REL;
    else if (roll < 98) cmd = CMD_DEPART_REQ;
    else                cmd = CMD_UNUSED;
    if ($urandom_range(0, 9) == 0) owner = OWNER_IN_W'($urandom_range(0, 65535));
    else                           owner = owner_pool[$urandom_range(0, POOL_SIZE - 1)];
    case ($urandom_range(0, 7))
      0:       pdraw = PEND_LIMIT - 15'd1;
      1:       pdraw = PEND_LIMIT;
      default: pdraw = DRAW_W'($urandom_range(0, 32767));
    endcase
    case ($urandom_range(0, 7))
      0:       kdraw = '0;
      1:       kdraw = '1;
      default: kdraw = DRAW_W'($urandom_range(0, 32767));
    endcase
    send_cmd(cmd, $urandom_range(0, 6) != 0, SLOT_IN_W'($urandom_range(0, 15)), owner,
             pdraw, kdraw);
  endtask

  // Drain every outstanding result, let the block settle, then write the
  // slot count register.
  task automatic write_slot_count(logic [CFG_W-1:0] n);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (8) @(posedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= n;
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
  endtask

  // Receiver: random stalls, or a long hold-off when one is asked for
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done <= holds_done + 1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] settings [SETTING_COUNT];
    settings = '{5'd16, 5'd31, 5'd0, 5'd7, 5'd1, 5'd16, 5'd12, 5'd2, 5'd16};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: four active slots so the table fills quickly
    write_slot_count(5'd4);
    send_cmd(CMD_FORCE,      1'b0, 4'd0,  16'h1111, 15'd0,     15'd0);     // no slot named
    send_cmd(CMD_FORCE,      1'b1, 4'd15, 16'hFFFF, 15'h7FFF,  15'h7FFF);  // beyond active
    send_cmd(CMD_FORCE,      1'b1, 4'd0,  16'hFFFF, 15'd0,     15'd0);
    send_cmd(CMD_FORCE,      1'b1, 4'd0,  16'h0001, 15'd0,     15'd0);     // take over
    send_cmd(CMD_OCCUPY,     1'b1, 4'd0,  16'hA5A5, 15'd0,     15'h7FFF);  // busy, last free
    send_cmd(CMD_OCCUPY,     1'b1, 4'd1,  16'h5A5A, 15'd0,     15'd0);     // preferred free
    send_cmd(CMD_OCCUPY,     1'b0, 4'd0,  16'h5A5A, 15'd0,     15'd0);     // only one left
    send_cmd(CMD_OCCUPY,     1'b1, 4'd2,  16'h2222, 15'd0,     15'd0);     // table full
    send_cmd(CMD_QUERY,      1'b0, 4'd0,  16'h5A5A, 15'd0,     15'd0);
    send_cmd(CMD_QUERY,      1'b0, 4'd0,  16'h1234, 15'd0,     15'd0);     // no match
    send_cmd(CMD_RELEASE,    1'b0, 4'd0,  16'h0001, 15'd0,     15'd0);
    send_cmd(CMD_RESERVE,    1'b0, 4'd0,  16'hFFFF, PEND_LIMIT - 15'd1, 15'd0);
    send_cmd(CMD_RESERVE,    1'b0, 4'd0,  16'hFFFF, PEND_LIMIT, 15'd0);
    send_cmd(CMD_RESERVE,    1'b0, 4'd0,  16'h3333, 15'h7FFF,  15'h7FFF);  // none free
    send_cmd(CMD_DEPART_REL, 1'b0, 4'd0,  16'hFFFF, 15'd0,     15'd0);     // reserved stays
    send_cmd(CMD_QUERY,      1'b0, 4'd0,  16'hFFFF, 15'd0,     15'd0);     // reserved only
    send_cmd(CMD_FORCE,      1'b1, 4'd0,  16'h0000, 15'd0,     15'd0);     // over reserved
    send_cmd(CMD_DEPART_REQ, 1'b0, 4'd0,  16'h0000, 15'd0,     15'd0);
    send_cmd(CMD_DEPART_REQ, 1'b0, 4'd0,  16'h0000, 15'h7FFF,  15'd0);
    send_cmd(CMD_DEPART_REQ, 1'b0, 4'd0,  16'h0000, PEND_LIMIT, 15'd0);
    send_cmd(CMD_UNUSED,     1'b1, 4'd3,  16'hFFFF, 15'h7FFF,  15'h7FFF);
    send_cmd(CMD_RELEASE,    1'b0, 4'd0,  16'hA5A5, 15'd0,     15'd0);
    send_cmd(CMD_OCCUPY,     1'b1, 4'd9,  16'h4444, 15'd0,     15'h4000);  // preference ignored
    send_cmd(CMD_DEPART_REL, 1'b0, 4'd0,  16'h5A5A, 15'd0,     15'd0);

    // Random phases, one per slot count setting
    for (int s = 0; s < SETTING_COUNT; s++) begin
      write_slot_count(settings[s]);
      foreach (owner_pool[k]) owner_pool[k] = OWNER_IN_W'($urandom_range(0, 65535));
      // Hold the receiver off while commands keep coming, so the input stalls
      if (s == 7) holds_asked <= holds_asked + 1;
      repeat (ITEMS_PER_SET) send_random();
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("owner_tagged_slot_allocator: match");
    end else begin
      $display("owner_tagged_slot_allocator: mismatch");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("owner_tagged_slot_allocator: mismatch");
    $finish;
  end

endmodule

// ===== owner_tagged_slot_allocator.f =====
src/otsa_pkg.sv
src/otsa_dp.sv
src/otsa_ctrl.sv
src/owner_tagged_slot_allocator.sv
dv/owner_tagged_slot_allocator_checker.sv
dv/owner_tagged_slot_allocator_tb.sv
